// ===== rtl/core/smon_pkg.sv =====
// Package: shared constants, types and register codes of the spark duration monitor.
`default_nettype none

package smon_pkg;

    localparam int NUM_COILS     = 4;
    localparam int TIME_BITS     = 32;
    localparam int FIRST_IGN_PIN = 4;

    localparam logic [7:0]  IGN_PINS          = 8'hF0;
    localparam logic [31:0] SHORT_TICKS_RESET = 32'd150;
    localparam logic [31:0] TIME_MASK         =
        (TIME_BITS >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << TIME_BITS) - 64'd1);

    localparam int CFG_IDX_BITS = 4;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_SENSE_PRESENT = 4'd0,
        CFG_SHORT_TICKS   = 4'd1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        PH_IDLE       = 2'd0,
        PH_WAIT_START = 2'd1,
        PH_WAIT_END   = 2'd2
    } t_phase;

    typedef struct packed {
        logic        sense_present;
        logic [31:0] short_ticks;
    } t_cfg;

    typedef struct packed {
        logic        func;
        logic [2:0]  pin;
        logic        level;
        logic        sense_level;
        logic [31:0] time_now;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  out_state;
        logic [1:0]  coil_phase;
        logic [1:0]  active_coil;
        logic [3:0]  spark_fault;
        logic        duration_valid;
        logic [1:0]  duration_coil;
        logic [31:0] duration_ticks;
        logic        short_spark;
        logic [15:0] sync_errors;
    } t_out_item;

endpackage

`default_nettype wire

// ===== rtl/core/smon_intf.sv =====
// Interfaces: item, result and configuration channels.
`default_nettype none

interface smon_in_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [2:0]  pin;
    logic        level;
    logic        sense_level;
    logic [31:0] time_now;

    modport source (output valid, output func, output pin, output level,
                    output sense_level, output time_now, input ready);
    modport sink   (input valid, input func, input pin, input level,
                    input sense_level, input time_now, output ready);
endinterface

interface smon_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_state;
    logic [1:0]  coil_phase;
    logic [1:0]  active_coil;
    logic [3:0]  spark_fault;
    logic        duration_valid;
    logic [1:0]  duration_coil;
    logic [31:0] duration_ticks;
    logic        short_spark;
    logic [15:0] sync_errors;

    modport source (output valid, output out_state, output coil_phase,
                    output active_coil, output spark_fault, output duration_valid,
                    output duration_coil, output duration_ticks, output short_spark,
                    output sync_errors, input ready);
    modport sink   (input valid, input out_state, input coil_phase,
                    input active_coil, input spark_fault, input duration_valid,
                    input duration_coil, input duration_ticks, input short_spark,
                    input sync_errors, output ready);
endinterface

interface smon_cfg_if;
    logic        valid;
    logic        ready;
    logic [3:0]  index;
    logic [31:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/smon_cfg_regs.sv =====
// Configuration registers: sense enable and short-spark threshold.
`default_nettype none

module smon_cfg_regs
    import smon_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_wr,
    input  wire logic [CFG_IDX_BITS-1:0] i_index,
    input  wire logic [31:0] i_data,
    output t_cfg      o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr) begin
            case (t_cfg_idx'(i_index))
                CFG_SENSE_PRESENT: n_cfg.sense_present = i_data[0];
                CFG_SHORT_TICKS:   n_cfg.short_ticks   = i_data;
                default:           n_cfg = r_cfg;   // unmapped index, dropped
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sense_present <= 1'b0;
            r_cfg.short_ticks   <= SHORT_TICKS_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== rtl/core/smon_core.sv =====
// Core: pin state, coil supervision state and the per-beat update.
`default_nettype none

module smon_core
    import smon_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_accept,
    input  wire t_in_item  i_item,
    input  wire t_cfg      i_cfg,
    output t_out_item      o_res
);

    logic [7:0]  r_pins,  n_pins;
    t_phase      r_phase, n_phase;
    logic [1:0]  r_coil,  n_coil;
    logic [3:0]  r_fault, n_fault;
    logic [15:0] r_err_count, n_err_count;
    logic [31:0] r_start [4];

    logic [7:0]  wr_bit;
    logic [7:0]  pins_wr;
    logic        coil_ok;
    logic        start_we;
    logic        rec_valid;
    logic [1:0]  rec_coil;
    logic [31:0] rec_ticks;

    always_comb begin
        n_pins      = r_pins;
        n_phase     = r_phase;
        n_coil      = r_coil;
        n_fault     = r_fault;
        n_err_count = r_err_count;
        start_we    = 1'b0;
        rec_valid   = 1'b0;
        rec_coil    = 2'd0;
        rec_ticks   = 32'd0;

        wr_bit   = 8'(8'd1 << i_item.pin);
        pins_wr  = i_item.level ? (r_pins | wr_bit) : (r_pins & ~wr_bit);
        coil_ok  = (32'(i_item.pin) - 32'(FIRST_IGN_PIN)) < 32'(NUM_COILS);

        if (!i_item.func) begin
            // falling ignition pin arms its coil; a pending coil is faulted first
            if ((wr_bit & IGN_PINS) != 8'd0 && i_cfg.sense_present &&
                pins_wr != r_pins && !i_item.level && coil_ok) begin
                if (r_phase != PH_IDLE) begin
                    n_fault   = r_fault | 4'(4'd1 << r_coil);
                    rec_valid = 1'b1;
                    rec_coil  = r_coil;
                end
                n_coil  = i_item.pin[1:0];
                n_phase = PH_WAIT_START;
            end
            n_pins = pins_wr;
        end else if (i_cfg.sense_present && r_phase != PH_IDLE) begin
            if (!i_item.sense_level && r_phase == PH_WAIT_START) begin
                start_we = 1'b1;
                n_phase  = PH_WAIT_END;
            end else if (i_item.sense_level && r_phase == PH_WAIT_END) begin
                rec_valid = 1'b1;
                rec_coil  = r_coil;
                rec_ticks = (i_item.time_now - r_start[r_coil]) & TIME_MASK;
                n_fault   = r_fault & ~4'(4'd1 << r_coil);
                n_phase   = PH_IDLE;
            end else begin
                // out-of-order edge
                if (r_err_count != 16'hFFFF) begin
                    n_err_count = r_err_count + 16'd1;
                end
                n_fault   = r_fault | 4'(4'd1 << r_coil);
                rec_valid = 1'b1;
                rec_coil  = r_coil;
                n_phase   = PH_IDLE;
            end
        end
    end

    always_comb begin
        o_res.out_state      = n_pins;
        o_res.coil_phase     = n_phase;
        o_res.active_coil    = n_coil;
        o_res.spark_fault    = n_fault;
        o_res.duration_valid = rec_valid;
        o_res.duration_coil  = rec_coil;
        o_res.duration_ticks = rec_ticks;
        o_res.short_spark    = rec_valid && (rec_ticks < i_cfg.short_ticks);
        o_res.sync_errors    = n_err_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pins      <= 8'd0;
            r_phase     <= PH_IDLE;
            r_coil      <= 2'd0;
            r_fault     <= 4'd0;
            r_err_count <= 16'd0;
        end else if (i_accept) begin
            r_pins      <= n_pins;
            r_phase     <= n_phase;
            r_coil      <= n_coil;
            r_fault     <= n_fault;
            r_err_count <= n_err_count;
        end
    end

    // a coil's start stamp is always written by an earlier beat before its end edge reads it
    always_ff @(posedge i_clk) begin
        if (i_accept && start_we) begin
            r_start[r_coil] <= i_item.time_now;
        end
    end

    a_no_sense_edge_ignored: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && i_item.func && !i_cfg.sense_present
        |=> r_phase == $past(r_phase) && r_fault == $past(r_fault))
        else $error("sense edge changed state with sense absent");

    a_err_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> r_err_count >= $past(r_err_count))
        else $error("sync error count went down");

    a_record_ends_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && o_res.duration_valid |=> r_phase != PH_WAIT_END)
        else $error("recorded duration left coil waiting for spark end");

    a_pin_write_no_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && !i_item.func |=> r_err_count == $past(r_err_count))
        else $error("pin write counted a sync error");

endmodule

`default_nettype wire

// ===== rtl/core/smon_out_reg.sv =====
// Result register: holds one finished result until the sink takes it.
`default_nettype none

module smon_out_reg
    import smon_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_load,
    input  wire t_out_item i_res,
    input  wire logic      i_take,
    output logic           o_valid,
    output logic           o_free,
    output t_out_item      o_res
);

    logic      r_valid;
    logic      n_valid;
    t_out_item r_res;

    // free when empty or emptied this cycle
    assign o_free  = !r_valid || i_take;
    assign n_valid = i_load || (r_valid && !i_take);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

`default_nettype wire

// ===== rtl/core/spark_duration_monitor_top.sv =====
// Top level of the spark duration monitor.
//
//  channel   | dir | handshake            | payload
//  ----------+-----+----------------------+------------------------------------------
//  i_item    | in  | valid/ready          | func, pin, level, sense_level, time_now
//  o_result  | out | valid/ready          | pin state, coil status, duration, errors
//  i_cfg     | in  | valid/ready (ready=1)| register index, write data
//
//  One item per clock: the core updates its state and builds the result in the
//  cycle of the accepted beat; the result register presents it the next cycle.
//  Throughput is set by the single result register, which reloads in the cycle
//  it is drained, so a new beat is taken every cycle while the sink keeps up.
//  A stalled result holds the item channel off (ready low) until taken.
//  Reset (i_rst_n low, synchronous) clears pin state, phase, faults, error count,
//  the result register and the configuration (sense off, threshold 150 ticks).
//  Configuration writes are always accepted when offered.
`default_nettype none

module spark_duration_monitor_top
    import smon_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    smon_in_if.sink      i_item,
    smon_out_if.source   o_result,
    smon_cfg_if.sink     i_cfg
);

    t_cfg      cfg;
    t_in_item  item;
    t_out_item core_res;
    t_out_item out_res;
    logic      accept;
    logic      out_free;
    logic      out_valid;

    // configuration port never stalls
    assign i_cfg.ready = 1'b1;

    smon_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg.valid),
        .i_index (i_cfg.index),
        .i_data  (i_cfg.data),
        .o_cfg   (cfg)
    );

    always_comb begin
        item.func        = i_item.func;
        item.pin         = i_item.pin;
        item.level       = i_item.level;
        item.sense_level = i_item.sense_level;
        item.time_now    = i_item.time_now;
    end

    // item beat goes through whenever the result slot is or becomes free
    assign i_item.ready = out_free;
    assign accept       = i_item.valid && out_free;

    smon_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (item),
        .i_cfg    (cfg),
        .o_res    (core_res)
    );

    smon_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (accept),
        .i_res   (core_res),
        .i_take  (o_result.ready),
        .o_valid (out_valid),
        .o_free  (out_free),
        .o_res   (out_res)
    );

    assign o_result.valid          = out_valid;
    assign o_result.out_state      = out_res.out_state;
    assign o_result.coil_phase     = out_res.coil_phase;
    assign o_result.active_coil    = out_res.active_coil;
    assign o_result.spark_fault    = out_res.spark_fault;
    assign o_result.duration_valid = out_res.duration_valid;
    assign o_result.duration_coil  = out_res.duration_coil;
    assign o_result.duration_ticks = out_res.duration_ticks;
    assign o_result.short_spark    = out_res.short_spark;
    assign o_result.sync_errors    = out_res.sync_errors;

endmodule

`default_nettype wire
